// ===== sv/tofi_pkg.sv =====
package tofi_pkg;

  localparam int COEF_W     = 24;
  localparam int DATA_W     = 32;
  localparam int TIME_W     = 32;
  localparam int PER_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int NCOEF      = 3;
  localparam int PROD_W     = COEF_W + DATA_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int RND_W      = ACC_W - FRAC_W;
  localparam int DUE_W      = TIME_W + 2;
  localparam int DIV_CNT_W  = $clog2(TIME_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FB_COEF_0   = 3'd0,
    CFG_FB_COEF_1   = 3'd1,
    CFG_FB_COEF_2   = 3'd2,
    CFG_FF_COEF_0   = 3'd3,
    CFG_FF_COEF_1   = 3'd4,
    CFG_FF_COEF_2   = 3'd5,
    CFG_SAMPLE_PER  = 3'd6,
    CFG_SAMPLE_SKEW = 3'd7
  } cfg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FB   = 6'b000010,
    S_FF   = 6'b000100,
    S_ACC  = 6'b001000,
    S_WR   = 6'b010000,
    S_DUE  = 6'b100000
  } mac_state_t;

endpackage

// ===== sv/tofi_in_if.sv =====
interface tofi_in_if import tofi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [TIME_W-1:0] now_time;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, output now_time, output sample, input ready);
  modport sink (input valid, input now_time, input sample, output ready);
endinterface

// ===== sv/tofi_out_if.sv =====
interface tofi_out_if import tofi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered_value;
  logic        [TIME_W-1:0] next_due_time;
  logic                     updated;

  modport source (output valid, output filtered_value, output next_due_time,
                  output updated, input ready);
  modport sink (input valid, input filtered_value, input next_due_time,
                input updated, output ready);
endinterface

// ===== sv/timed_observable_form_iir_core.sv =====
// Channel  | Direction | Payload
// in_ch    | sink      | now_time, sample
// out_ch   | source    | filtered_value, next_due_time, updated
// cfg_*    | write     | cfg_index selects one of eight registers, cfg_data
//
// An item that advances the state goes through the FB, FF, ACC and WR states for each
// state element, one multiplier serving all multiply-accumulate steps, while a radix-2
// remainder unit works out the due time alongside them; S_DUE waits for it to finish.
// An item that holds the state has its result pending in the cycle after acceptance.
// The next beat can be accepted in the cycle after the result is loaded.
// The result sits in an output register, so a stalled sink only delays the next item
// once a second result is ready. Reset is synchronous and clears filter state and flags.
module timed_observable_form_iir_core import tofi_pkg::*; #(
  parameter int STATE_ORDER = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tofi_in_if.sink               in_ch,
  tofi_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (STATE_ORDER > 1) ? $clog2(STATE_ORDER) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(STATE_ORDER - 1);

  mac_state_t state_r;

  logic signed [COEF_W-1:0] fb_coef_r [NCOEF];
  logic signed [COEF_W-1:0] ff_coef_r [NCOEF];
  logic        [PER_W-1:0]  period_r;
  logic        [PER_W-1:0]  skew_r;

  logic signed [DATA_W-1:0] x_r [STATE_ORDER];
  logic        [TIME_W-1:0] due_r;

  logic        [TIME_W-1:0] now_r;
  logic signed [DATA_W-1:0] u_r;
  logic signed [DATA_W-1:0] xl_r;
  logic        [IDX_W-1:0]  idx_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic        [DIV_CNT_W-1:0] div_cnt_r;
  logic        [TIME_W-1:0]    dvd_r;
  logic        [PER_W-1:0]     rem_r;

  logic                     res_pend_r;
  logic                     upd_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_fv_r;
  logic        [TIME_W-1:0] out_due_r;
  logic                     out_upd_r;

  logic                     in_fire;
  logic                     do_update;
  logic                     out_load;
  logic        [PER_W-1:0]  per_eff;
  logic signed [COEF_W-1:0] fb_sel;
  logic signed [COEF_W-1:0] ff_sel;
  logic signed [COEF_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [RND_W-1:0]  rnd;
  logic signed [DATA_W-1:0] sat_val;
  logic        [PER_W:0]    div_t;
  logic        [DUE_W-1:0]  nd;
  logic        [TIME_W-1:0] nd_sat;

  assign in_ch.ready = (state_r == S_IDLE) && !res_pend_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign do_update   = due_r <= in_ch.now_time;
  assign out_load    = res_pend_r && (!out_valid_r || out_ch.ready);
  assign per_eff     = (period_r == '0) ? PER_W'(1) : period_r;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_value = out_fv_r;
  assign out_ch.next_due_time  = out_due_r;
  assign out_ch.updated        = out_upd_r;

  always_comb begin
    fb_sel = '0;
    ff_sel = '0;
    for (int k = 0; k < NCOEF; k++) begin
      if (32'(idx_r) == k) begin
        fb_sel = fb_coef_r[k];
        ff_sel = ff_coef_r[k];
      end
    end
  end

  assign mul_a    = (state_r == S_FB) ? fb_sel : ff_sel;
  assign mul_b    = (state_r == S_FB) ? xl_r : u_r;
  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    base = '0;
    if (idx_r != '0) begin
      base = {{(ACC_W - DATA_W - FRAC_W){x_r[IDX_W'(idx_r - 1'b1)][DATA_W-1]}},
              x_r[IDX_W'(idx_r - 1'b1)], {FRAC_W{1'b0}}};
    end
  end

  assign rnd_sum = acc_r + ACC_W'(1 << (FRAC_W - 1));
  assign rnd     = rnd_sum[ACC_W-1:FRAC_W];

  always_comb begin
    if (rnd[RND_W-1:DATA_W-1] == '0 || rnd[RND_W-1:DATA_W-1] == '1) begin
      sat_val = rnd[DATA_W-1:0];
    end else if (rnd[RND_W-1]) begin
      sat_val = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W - 1){1'b1}}};
    end
  end

  assign div_t  = {rem_r, dvd_r[TIME_W-1]};
  assign nd     = DUE_W'(now_r) - DUE_W'(rem_r) + DUE_W'(per_eff) + DUE_W'(skew_r);
  assign nd_sat = (nd[DUE_W-1:TIME_W] != '0) ? '1 : nd[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NCOEF; k++) begin
        fb_coef_r[k] <= '0;
        ff_coef_r[k] <= '0;
      end
      period_r <= PER_W'(1);
      skew_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FB_COEF_0:   fb_coef_r[0] <= cfg_data;
        CFG_FB_COEF_1:   fb_coef_r[1] <= cfg_data;
        CFG_FB_COEF_2:   fb_coef_r[2] <= cfg_data;
        CFG_FF_COEF_0:   ff_coef_r[0] <= cfg_data;
        CFG_FF_COEF_1:   ff_coef_r[1] <= cfg_data;
        CFG_FF_COEF_2:   ff_coef_r[2] <= cfg_data;
        CFG_SAMPLE_PER:  period_r <= cfg_data[PER_W-1:0];
        CFG_SAMPLE_SKEW: skew_r <= cfg_data[PER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (in_fire && do_update) begin
      div_cnt_r <= DIV_CNT_W'(TIME_W);
    end else if (div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dvd_r <= in_ch.now_time;
      rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      dvd_r <= {dvd_r[TIME_W-2:0], 1'b0};
      if (div_t >= {1'b0, per_eff}) begin
        rem_r <= PER_W'(div_t - {1'b0, per_eff});
      end else begin
        rem_r <= div_t[PER_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_pend_r <= 1'b0;
      upd_r      <= 1'b0;
      due_r      <= '0;
      for (int k = 0; k < STATE_ORDER; k++) begin
        x_r[k] <= '0;
      end
    end else begin
      if (out_load) begin
        res_pend_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (do_update) begin
              state_r <= S_FB;
            end else begin
              upd_r      <= 1'b0;
              res_pend_r <= 1'b1;
            end
          end
        end
        S_FB:  state_r <= S_FF;
        S_FF:  state_r <= S_ACC;
        S_ACC: state_r <= S_WR;
        S_WR: begin
          x_r[idx_r] <= sat_val;
          state_r    <= (idx_r == '0) ? S_DUE : S_FB;
        end
        S_DUE: begin
          if (div_cnt_r == '0) begin
            due_r      <= nd_sat;
            upd_r      <= 1'b1;
            res_pend_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r <= in_ch.now_time;
      u_r   <= in_ch.sample;
      xl_r  <= x_r[LAST];
      idx_r <= LAST;
    end
    if (state_r == S_WR && idx_r != '0) begin
      idx_r <= idx_r - 1'b1;
    end
    if (state_r == S_FB || state_r == S_FF) begin
      prod_r <= mul_p;
    end
    if (state_r == S_FF) begin
      acc_r <= base - prod_ext;
    end
    if (state_r == S_ACC) begin
      acc_r <= acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fv_r  <= x_r[LAST];
      out_due_r <= due_r;
      out_upd_r <= upd_r;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tofi_pkg::*;

  localparam int ORDER = 3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh80000000;
  localparam logic [TIME_W-1:0] TIME_MAX = 32'hFFFFFFFF;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [TIME_W-1:0]        due;
    logic                     updated;
  } filter_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tofi_in_if  in_ch ();
  tofi_out_if out_ch ();

  timed_observable_form_iir_core #(.STATE_ORDER(ORDER)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic signed [COEF_W-1:0] fb_c [NCOEF];
  logic signed [COEF_W-1:0] ff_c [NCOEF];
  logic [PER_W-1:0]         period_r;
  logic [PER_W-1:0]         skew_r;
  logic signed [DATA_W-1:0] x_st [ORDER];
  logic [TIME_W-1:0]        due_st;

  filter_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic filter_result_t advance_filter(input logic [TIME_W-1:0] t,
                                                    input logic signed [DATA_W-1:0] u);
    filter_result_t r;
    logic signed [DATA_W-1:0] nx [ORDER];
    longint acc;
    longint xl;
    logic [63:0] per;
    logic [63:0] nd;
    int i;
    r.updated = 1'b0;
    if (due_st <= t) begin
      xl = x_st[ORDER-1];
      for (i = 0; i < ORDER; i++) begin
        acc = 0;
        if (i < NCOEF)
          acc = -(longint'(fb_c[i]) * xl) + longint'(ff_c[i]) * longint'(u);
        if (i > 0)
          acc += longint'(x_st[i-1]) <<< 16;
        acc = (acc + 64'sd32768) >>> 16;
        if (acc > 64'sd2147483647)
          nx[i] = SAMPLE_MAX;
        else if (acc < -64'sd2147483648)
          nx[i] = SAMPLE_MIN;
        else
          nx[i] = acc[31:0];
      end
      x_st = nx;
      per = (period_r == 0) ? 64'd1 : {48'd0, period_r};
      nd = ({32'd0, t} / per + 64'd1) * per + {48'd0, skew_r};
      due_st = (nd > 64'hFFFFFFFF) ? TIME_MAX : nd[31:0];
      r.updated = 1'b1;
    end
    r.value = x_st[ORDER-1];
    r.due = due_st;
    return r;
  endfunction

  always @(posedge clk) begin
    filter_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat: value=%0d due=%0d updated=%0b", $time,
                 out_ch.filtered_value, out_ch.next_due_time, out_ch.updated);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.filtered_value !== want.value || out_ch.next_due_time !== want.due ||
            out_ch.updated !== want.updated) begin
          $display("%0t: mismatch: expected value=%0d due=%0d updated=%0b", $time,
                   want.value, want.due, want.updated);
          $display("%0t:           actual value=%0d due=%0d updated=%0b", $time,
                   out_ch.filtered_value, out_ch.next_due_time, out_ch.updated);
          errors++;
        end
      end
    end
  end

  initial begin
    int mode;
    int left;
    int tick;
    out_ch.ready <= 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 160);
      end
      left--;
      tick++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (tick % 5 == 0);
        default: out_ch.ready <= ($urandom_range(0, 19) == 0);
      endcase
    end
  end

  task automatic send_sample(input logic [TIME_W-1:0] t, input logic signed [DATA_W-1:0] s);
    in_ch.valid <= 1'b1;
    in_ch.now_time <= t;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(advance_filter(t, s));
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic load_config(input logic signed [COEF_W-1:0] a0, a1, a2, b0, b1, b2,
                             input logic [PER_W-1:0] per, skew);
    wait_for_results();
    write_reg(CFG_FB_COEF_0, a0);
    write_reg(CFG_FB_COEF_1, a1);
    write_reg(CFG_FB_COEF_2, a2);
    write_reg(CFG_FF_COEF_0, b0);
    write_reg(CFG_FF_COEF_1, b1);
    write_reg(CFG_FF_COEF_2, b2);
    write_reg(CFG_SAMPLE_PER, {{(CFG_DATA_W-PER_W){1'b0}}, per});
    write_reg(CFG_SAMPLE_SKEW, {{(CFG_DATA_W-PER_W){1'b0}}, skew});
    cfg_we <= 1'b0;
    fb_c = '{a0, a1, a2};
    ff_c = '{b0, b1, b2};
    period_r = per;
    skew_r = skew;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return COEF_MAX;
      2: return COEF_MIN;
      3, 4: return COEF_W'($urandom);
      default: return COEF_W'(int'($urandom_range(0, 'h10000)) - 'h8000);
    endcase
  endfunction

  function automatic logic [PER_W-1:0] pick_period();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PER_W'($urandom);
      2: return 16'd1;
      default: return PER_W'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic logic [PER_W-1:0] pick_skew();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return PER_W'($urandom);
      default: return PER_W'($urandom_range(0, 10));
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3, 4: return $urandom;
      default: return int'($urandom_range(0, 'h3FFFF)) - 'h20000;
    endcase
  endfunction

  // Most beats land at or just past the due time so the state keeps advancing;
  // the rest fall before it and must be held.
  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned span;
    logic [63:0] t;
    span = (period_r == 0) ? 1 : period_r;
    case ($urandom_range(0, 9))
      0, 1: t = (due_st == 0) ? 64'd0 : {32'd0, $urandom % due_st};
      2: t = (due_st == 0) ? 64'd0 : {32'd0, due_st - 32'd1};
      default: t = {32'd0, due_st} + $urandom_range(0, span - 1);
    endcase
    if (t > 64'hFFFFFFFF)
      t = 64'hFFFFFFFF;
    return t[TIME_W-1:0];
  endfunction

  task automatic test_reset_defaults();
    send_sample(0, SAMPLE_MAX);
    send_sample(0, SAMPLE_MIN);
    send_sample(1, 0);
  endtask

  task automatic test_coef_extremes();
    load_config(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, 16'd0, 16'hFFFF);
    repeat (4) send_sample(due_st, SAMPLE_MAX);
    send_sample(due_st - 1, SAMPLE_MIN);
    repeat (3) send_sample(due_st, SAMPLE_MIN);
    send_sample(due_st + 5, 0);
    load_config(COEF_MIN, COEF_MAX, COEF_MIN, '0, '0, COEF_MAX, 16'hFFFF, 16'd0);
    send_sample(due_st, 1);
    send_sample(due_st + 32'd65534, -1);
    send_sample(due_st - 1, SAMPLE_MAX);
    send_sample(due_st, SAMPLE_MIN);
  endtask

  task automatic test_feedback_only();
    load_config(24'sh008000, -24'sh004000, 24'sh002000, '0, '0, '0, 16'd3, 16'd2);
    send_sample(due_st, SAMPLE_MAX);
    send_sample(due_st + 2, SAMPLE_MAX);
    send_sample(due_st, 0);
  endtask

  task automatic test_random_streams();
    int phase;
    int n;
    logic [TIME_W-1:0] base;
    for (phase = 0; phase < 10; phase++) begin
      load_config(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                  pick_coef(), pick_period(), pick_skew());
      base = (32'(phase) << 28) | ($urandom & 32'h0FFFFFFF);
      if (base > due_st)
        send_sample(base, pick_sample());
      for (n = 0; n < 100; n++) begin
        pace_sender();
        if (phase == 4 && n == 50)
          wait_for_results();
        send_sample(pick_time(), pick_sample());
      end
    end
  endtask

  // A saturated due time can never come down again, so this runs last.
  task automatic test_due_saturation();
    load_config(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                pick_coef(), 16'hFFFF, 16'hFFFF);
    send_sample(32'hFFFF0000, SAMPLE_MAX);
    send_sample(TIME_MAX - 1, SAMPLE_MIN);
    send_sample(TIME_MAX, SAMPLE_MAX);
    load_config(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, 16'd0, 16'd0);
    send_sample(TIME_MAX, SAMPLE_MIN);
    send_sample(TIME_MAX, SAMPLE_MAX);
    send_sample(TIME_MAX - 32'h12345, 0);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FB_COEF_0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.now_time <= '0;
    in_ch.sample <= '0;
    fb_c = '{default: '0};
    ff_c = '{default: '0};
    period_r = 16'd1;
    skew_r = 16'd0;
    x_st = '{default: '0};
    due_st = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_coef_extremes();
    test_feedback_only();
    test_random_streams();
    test_due_saturation();

    wait_for_results();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
